/* design/ecg_display_decimator_top_assert.svh */
// assertion macros used by the checker file
`ifndef ECG_DISPLAY_DECIMATOR_TOP_ASSERT_SVH
`define ECG_DISPLAY_DECIMATOR_TOP_ASSERT_SVH

// generic clocked assertion, off during reset
`define ECGDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property that only needs to hold while a result item is offered
`define ECGDD_ASSERT_OUT(lbl, prop, msg) \
  `ECGDD_ASSERT(lbl, out_valid_o |-> (prop), msg)

`endif

/* design/ecgdd_pkg.sv */
package ecgdd_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = 16 + $clog2(MAX_WINDOW);

  localparam int DIV_W = 32;
  localparam int DVS_W = 16;
  localparam int NB_W  = $clog2(DIV_W + 1);

  localparam int FIFO_DEPTH = 2;

  localparam int BEAT_NUM  = 60000;
  localparam int BASELINE  = 100;
  localparam int POINT_MAX = 200;

  localparam logic [9:0] PERIOD_RST = 10'd20;
  localparam logic [7:0] LOW_RST    = 8'd30;
  localparam logic [7:0] HIGH_RST   = 8'd220;
  localparam logic [9:0] FLASH_RST  = 10'd150;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_PERIOD = 2'd0,
    CFG_LOW    = 2'd1,
    CFG_HIGH   = 2'd2,
    CFG_FLASH  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [9:0] period;
    logic [7:0] rate_low;
    logic [7:0] rate_high;
    logic [9:0] flash;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [7:0]         heart_rate;
    logic               leads_on;
    logic [31:0]        ms;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
    logic [NB_W-1:0]  nbits;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

endpackage

/* design/ecgdd_fifo.sv */
module ecgdd_fifo import ecgdd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_data_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  empty_o,
  output item_t head_o
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

  item_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [LVL_W-1:0]  level_q, level_d;
  logic              do_push, do_pop;

  assign full_o  = (level_q == LVL_W'(FIFO_DEPTH));
  assign empty_o = (level_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_d = level_q + 1'b1;
    end else if (do_pop && !do_push) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* design/ecgdd_front.sv */
module ecgdd_front import ecgdd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic signed [15:0] sample_i,
  input  logic [7:0]         heart_rate_i,
  input  logic               leads_on_i,
  input  logic               fifo_full_i,
  output logic               push_o,
  output item_t              push_data_o
);

  logic [31:0] ms_now_q, ms_now_d;
  logic        accept;
  logic        is_tick;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_tick    = (op_i == OP_TICK);

  // ticks stay here, samples go to the back end stamped with the current time
  assign push_o                 = accept && !is_tick;
  assign push_data_o.sample     = sample_i;
  assign push_data_o.heart_rate = heart_rate_i;
  assign push_data_o.leads_on   = leads_on_i;
  assign push_data_o.ms         = ms_now_q;

  always_comb begin
    ms_now_d = ms_now_q;
    if (accept && is_tick) begin
      ms_now_d = ms_now_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_now_q <= '0;
    end else begin
      ms_now_q <= ms_now_d;
    end
  end

endmodule

/* design/ecgdd_div.sv */
module ecgdd_div import ecgdd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [NB_W-1:0]  cnt_q, cnt_d;
  logic [DIV_W-1:0] dq_q, dq_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   trial;
  logic             fits;

  // restoring division, one quotient bit per cycle, msb first
  assign trial = {rem_q, dq_q[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.nbits;
      dq_d   = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      dq_d  = {dq_q[DIV_W-2:0], fits};
      rem_d = fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == NB_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dq_q   <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      dq_q   <= dq_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dq_q;
  assign rsp_o.rem  = rem_q;

endmodule

/* design/ecgdd_back.sv */
module ecgdd_back import ecgdd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       fifo_empty_i,
  input  item_t      head_i,
  output logic       pop_o,
  output div_req_t   div_req_o,
  input  div_rsp_t   div_rsp_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       point_valid_o,
  output logic [7:0] chart_point_o,
  output logic       lead_warning_o,
  output logic       rate_shown_o,
  output logic [7:0] rate_display_o,
  output logic       beat_bright_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_WIN  = 9'b000000010,
    S_EMIT = 9'b000000100,
    S_AVG  = 9'b000001000,
    S_RATE = 9'b000010000,
    S_BEAT = 9'b000100000,
    S_MOD  = 9'b001000000,
    S_OUT  = 9'b010000000,
    S_HOLD = 9'b100000000
  } state_e;

  state_e                    state_q, state_d;
  item_t                     item_q, item_d;
  logic                      emit_q, emit_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic signed [15:0]        peak_q, peak_d;
  logic                      open_q, open_d;
  logic [31:0]               last_emit_q, last_emit_d;

  logic                      r_pv_q, r_pv_d;
  logic [7:0]                r_pt_q, r_pt_d;
  logic                      r_warn_q, r_warn_d;
  logic                      r_shown_q, r_shown_d;
  logic [7:0]                r_disp_q, r_disp_d;
  logic                      r_bright_q, r_bright_d;

  logic                      ov_q, ov_d;
  logic                      o_pv_q, o_pv_d;
  logic [7:0]                o_pt_q, o_pt_d;
  logic                      o_warn_q, o_warn_d;
  logic                      o_shown_q, o_shown_d;
  logic [7:0]                o_disp_q, o_disp_d;
  logic                      o_bright_q, o_bright_d;

  // window update terms
  logic signed [16:0]        s_ext, p_ext;
  logic [16:0]               s_mag, p_mag;
  logic                      take_peak;
  logic [31:0]               elapsed;
  logic [SUM_W-1:0]          sum_mag;

  // chart point terms
  logic [15:0]               q_mag;
  logic signed [16:0]        avg_s;
  logic signed [19:0]        mix;
  logic signed [21:0]        mix5;
  logic signed [21:0]        mix_fl;
  logic signed [11:0]        level;
  logic [7:0]                point;
  logic                      rate_ok;

  assign s_ext     = 17'($signed(item_q.sample));
  assign p_ext     = 17'(peak_q);
  assign s_mag     = s_ext[16] ? 17'(-s_ext) : s_ext;
  assign p_mag     = p_ext[16] ? 17'(-p_ext) : p_ext;
  assign take_peak = !open_q || (s_mag > p_mag);
  assign elapsed   = item_q.ms - last_emit_q;
  assign sum_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  // avg truncates toward zero, so the sign goes back on the magnitude quotient
  assign q_mag  = div_rsp_i.quot[15:0];
  assign avg_s  = sum_q[SUM_W-1] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  assign mix    = (20'(avg_s) <<< 1) + 20'(avg_s) + 20'(peak_q);
  assign mix5   = (22'(mix) <<< 2) + 22'(mix);
  assign mix_fl = mix5 >>> 10;
  assign level  = 12'(mix_fl) + 12'(BASELINE);
  assign point  = (level < 0) ? 8'd0 :
                  (level > 12'(POINT_MAX)) ? 8'(POINT_MAX) : level[7:0];

  assign rate_ok = (item_q.heart_rate > cfg_i.rate_low) &&
                   (item_q.heart_rate < cfg_i.rate_high);

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    emit_d      = emit_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    peak_d      = peak_q;
    open_d      = open_q;
    last_emit_d = last_emit_q;
    r_pv_d      = r_pv_q;
    r_pt_d      = r_pt_q;
    r_warn_d    = r_warn_q;
    r_shown_d   = r_shown_q;
    r_disp_d    = r_disp_q;
    r_bright_d  = r_bright_q;
    ov_d        = ov_q && !out_ready_i;
    o_pv_d      = o_pv_q;
    o_pt_d      = o_pt_q;
    o_warn_d    = o_warn_q;
    o_shown_d   = o_shown_q;
    o_disp_d    = o_disp_q;
    o_bright_d  = o_bright_q;
    pop_o       = 1'b0;
    div_req_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o   = 1'b1;
          item_d  = head_i;
          state_d = S_WIN;
        end
      end
      S_WIN: begin
        r_pv_d     = 1'b0;
        r_pt_d     = 8'd0;
        r_warn_d   = 1'b0;
        r_shown_d  = 1'b0;
        r_disp_d   = 8'd0;
        r_bright_d = 1'b0;
        if (!item_q.leads_on) begin
          // leads off: fixed result, window untouched
          r_pv_d   = 1'b1;
          r_pt_d   = 8'(BASELINE);
          r_warn_d = 1'b1;
          state_d  = S_OUT;
        end else begin
          if (take_peak) begin
            peak_d = item_q.sample;
            open_d = 1'b1;
          end
          if (cnt_q < CNT_W'(MAX_WINDOW)) begin
            sum_d = sum_q + SUM_W'(item_q.sample);
            cnt_d = cnt_q + 1'b1;
          end
          emit_d = (elapsed >= 32'(cfg_i.period));
          if (elapsed >= 32'(cfg_i.period)) begin
            last_emit_d = item_q.ms;
          end
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_q) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {sum_mag, {(DIV_W - SUM_W){1'b0}}};
          div_req_o.divisor  = DVS_W'(cnt_q);
          div_req_o.nbits    = NB_W'(SUM_W);
          state_d            = S_AVG;
        end else begin
          state_d = S_RATE;
        end
      end
      S_AVG: begin
        if (div_rsp_i.done) begin
          r_pv_d  = 1'b1;
          r_pt_d  = (cnt_q == '0) ? 8'(BASELINE) : point;
          sum_d   = '0;
          cnt_d   = '0;
          peak_d  = '0;
          open_d  = 1'b0;
          state_d = S_RATE;
        end
      end
      S_RATE: begin
        if (rate_ok) begin
          r_shown_d          = 1'b1;
          r_disp_d           = item_q.heart_rate;
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {DVS_W'(BEAT_NUM), {(DIV_W - DVS_W){1'b0}}};
          div_req_o.divisor  = DVS_W'(item_q.heart_rate);
          div_req_o.nbits    = NB_W'(DVS_W);
          state_d            = S_BEAT;
        end else begin
          state_d = S_OUT;
        end
      end
      S_BEAT: begin
        if (div_rsp_i.done) begin
          // beat length in ms, then the phase of now within it
          div_req_o.start    = 1'b1;
          div_req_o.dividend = item_q.ms;
          div_req_o.divisor  = div_rsp_i.quot[DVS_W-1:0];
          div_req_o.nbits    = NB_W'(DIV_W);
          state_d            = S_MOD;
        end
      end
      S_MOD: begin
        if (div_rsp_i.done) begin
          r_bright_d = (div_rsp_i.rem < DVS_W'(cfg_i.flash));
          state_d    = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d       = 1'b1;
          o_pv_d     = r_pv_q;
          o_pt_d     = r_pt_q;
          o_warn_d   = r_warn_q;
          o_shown_d  = r_shown_q;
          o_disp_d   = r_disp_q;
          o_bright_d = r_bright_q;
          state_d    = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_ready_i) begin
          ov_d       = 1'b1;
          o_pv_d     = r_pv_q;
          o_pt_d     = r_pt_q;
          o_warn_d   = r_warn_q;
          o_shown_d  = r_shown_q;
          o_disp_d   = r_disp_q;
          o_bright_d = r_bright_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      emit_q      <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
      peak_q      <= '0;
      open_q      <= 1'b0;
      last_emit_q <= '0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      emit_q      <= emit_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      peak_q      <= peak_d;
      open_q      <= open_d;
      last_emit_q <= last_emit_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    r_pv_q     <= r_pv_d;
    r_pt_q     <= r_pt_d;
    r_warn_q   <= r_warn_d;
    r_shown_q  <= r_shown_d;
    r_disp_q   <= r_disp_d;
    r_bright_q <= r_bright_d;
    o_pv_q     <= o_pv_d;
    o_pt_q     <= o_pt_d;
    o_warn_q   <= o_warn_d;
    o_shown_q  <= o_shown_d;
    o_disp_q   <= o_disp_d;
    o_bright_q <= o_bright_d;
  end

  assign out_valid_o    = ov_q;
  assign point_valid_o  = o_pv_q;
  assign chart_point_o  = o_pt_q;
  assign lead_warning_o = o_warn_q;
  assign rate_shown_o   = o_shown_q;
  assign rate_display_o = o_disp_q;
  assign beat_bright_o  = o_bright_q;

endmodule

/* design/ecg_display_decimator_top.sv */
// ECG display decimator. Items are either ECG samples (op 0) or millisecond ticks (op 1);
// ticks only advance the internal clock and give no result, each sample gives exactly one
// result. A tick is taken whenever the input queue has room. With the leads off a sample
// goes straight to its result; with the leads on it updates the window, then closes it
// with a division (sum / count) when the period has elapsed, and when the heart rate is
// shown it divides twice more (60000 / rate, then time mod beat length). A sample may also
// wait for the previous result to be taken. All three divisions go through one shared
// divider that retires one quotient bit per cycle. A two-entry queue decouples input
// acceptance from processing, and a result register lets the next sample start while a
// finished result waits to be taken. Configuration is written through a plain write port
// and is to be changed only while the block is idle.
module ecg_display_decimator_top import ecgdd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [9:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic signed [15:0] sample_i,
  input  logic [7:0]         heart_rate_i,
  input  logic               leads_on_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               point_valid_o,
  output logic [7:0]         chart_point_o,
  output logic               lead_warning_o,
  output logic               rate_shown_o,
  output logic [7:0]         rate_display_o,
  output logic               beat_bright_o
);

  cfg_t     cfg_q, cfg_d;
  logic     fifo_full, fifo_empty;
  logic     push, pop;
  item_t    push_data, head;
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PERIOD: cfg_d.period    = cfg_wdata_i;
        CFG_LOW:    cfg_d.rate_low  = cfg_wdata_i[7:0];
        CFG_HIGH:   cfg_d.rate_high = cfg_wdata_i[7:0];
        CFG_FLASH:  cfg_d.flash     = cfg_wdata_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period    <= PERIOD_RST;
      cfg_q.rate_low  <= LOW_RST;
      cfg_q.rate_high <= HIGH_RST;
      cfg_q.flash     <= FLASH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ecgdd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .sample_i     (sample_i),
    .heart_rate_i (heart_rate_i),
    .leads_on_i   (leads_on_i),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  ecgdd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty),
    .head_o      (head)
  );

  ecgdd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ecgdd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .fifo_empty_i   (fifo_empty),
    .head_i         (head),
    .pop_o          (pop),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .point_valid_o  (point_valid_o),
    .chart_point_o  (chart_point_o),
    .lead_warning_o (lead_warning_o),
    .rate_shown_o   (rate_shown_o),
    .rate_display_o (rate_display_o),
    .beat_bright_o  (beat_bright_o)
  );

endmodule

/* design/ecgdd_checker.sv */
`include "ecg_display_decimator_top_assert.svh"

module ecgdd_checker import ecgdd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       point_valid_o,
  input logic [7:0] chart_point_o,
  input logic       lead_warning_o,
  input logic       rate_shown_o,
  input logic [7:0] rate_display_o,
  input logic       beat_bright_o
);

  `ECGDD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")
  `ECGDD_ASSERT_OUT(a_point_range, chart_point_o <= 8'(POINT_MAX), "chart point out of range")
  `ECGDD_ASSERT_OUT(a_leads_off, !lead_warning_o || (point_valid_o && chart_point_o == 8'(BASELINE) && !rate_shown_o && !beat_bright_o), "bad leads-off result")
  `ECGDD_ASSERT_OUT(a_rate_hidden, rate_shown_o || (rate_display_o == 8'd0 && !beat_bright_o), "hidden rate leaks")
  `ECGDD_ASSERT_OUT(a_no_point, point_valid_o || chart_point_o == 8'd0, "stale chart point")

endmodule

bind ecg_display_decimator_top ecgdd_checker u_checker (.*);
